[design/assert_macros.svh]
// assert_macros.svh
// Concurrent assertion helpers for the checker file ahsfb_chk.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising edge, skipped while reset is low.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Check a property at every rising edge, reset cycles included.
`define ASSERT_CLK_ALL(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) \
        else $error(msg);

`endif

[design/ahsfb_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ahsfb_pkg
// Types, character codes and helpers for the ASCII hex frame builder.
// ----------------------------------------------------------------------------
package ahsfb_pkg;

    localparam logic [7:0] ChColon   = 8'h3A;
    localparam logic [7:0] ChZero    = 8'h30;
    localparam logic [7:0] ChThree   = 8'h33;
    localparam logic [7:0] ChLetterA = 8'h41;
    localparam logic [7:0] ChCr      = 8'h0D;
    localparam logic [7:0] ChLf      = 8'h0A;

    localparam int FrameLen = 21;
    localparam int SumLen   = 17;

    localparam logic [4:0] PosColon  = 5'd0;
    localparam logic [4:0] PosIdHi   = 5'd1;
    localparam logic [4:0] PosIdLo   = 5'd2;
    localparam logic [4:0] PosFuncHi = 5'd3;
    localparam logic [4:0] PosFuncLo = 5'd4;
    localparam logic [4:0] PosSumHi  = 5'(SumLen);
    localparam logic [4:0] PosSumLo  = 5'(SumLen + 1);
    localparam logic [4:0] PosCr     = 5'(SumLen + 2);
    localparam logic [4:0] PosLast   = 5'(FrameLen - 1);

    typedef struct packed {
        logic [7:0]  device_id;
        logic [15:0] reading;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       frame_end;
    } t_out_item;

    // Controller to datapath commands.
    typedef struct packed {
        logic       load;  // capture a new input transaction
        logic       emit;  // build the byte at pos into the output register
        logic [4:0] pos;
    } t_dp_cmd;

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] ch;
        if (nib < 4'd10) begin
            ch = ChZero + {4'd0, nib};
        end else begin
            ch = ChLetterA + {4'd0, nib - 4'd10};
        end
        return ch;
    endfunction

endpackage

[design/ahsfb_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ahsfb_dp
// Frame datapath: held input, running checksum and output byte register.
// ----------------------------------------------------------------------------
module ahsfb_dp
    import ahsfb_pkg::*;
(
    input  logic      i_clk,
    input  t_dp_cmd   i_cmd,
    input  t_in_item  i_in_data,
    output t_out_item o_out_data
);

    logic [7:0]  r_id;
    logic [15:0] r_reading;
    logic [7:0]  r_sum;
    t_out_item   r_out;

    logic [1:0]  rd_sel;
    logic [3:0]  rd_nib;
    logic [7:0]  ch;

    // Reading digit index: top nibble first, repeating every four bytes.
    assign rd_sel = i_cmd.pos[1:0] - 2'd1;

    always_comb begin
        case (rd_sel)
            2'd0:    rd_nib = r_reading[15:12];
            2'd1:    rd_nib = r_reading[11:8];
            2'd2:    rd_nib = r_reading[7:4];
            default: rd_nib = r_reading[3:0];
        endcase
    end

    always_comb begin
        case (i_cmd.pos)
            PosColon:  ch = ChColon;
            PosIdHi:   ch = hex_char(r_id[7:4]);
            PosIdLo:   ch = hex_char(r_id[3:0]);
            PosFuncHi: ch = ChZero;
            PosFuncLo: ch = ChThree;
            PosSumHi:  ch = hex_char(r_sum[7:4]);
            PosSumLo:  ch = hex_char(r_sum[3:0]);
            PosCr:     ch = ChCr;
            PosLast:   ch = ChLf;
            default:   ch = hex_char(rd_nib);
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_id      <= i_in_data.device_id;
            r_reading <= i_in_data.reading;
            r_sum     <= '0;
        end else if (i_cmd.emit && (i_cmd.pos < PosSumHi)) begin
            r_sum <= r_sum + ch;
        end
        if (i_cmd.emit) begin
            r_out.out_byte  <= ch;
            r_out.frame_end <= (i_cmd.pos == PosLast);
        end
    end

    assign o_out_data = r_out;

endmodule

[design/ahsfb_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ahsfb_ctrl
// Frame sequencer: byte position counter and both channel handshakes.
// ----------------------------------------------------------------------------
module ahsfb_ctrl
    import ahsfb_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    output logic    o_out_valid,
    input  logic    i_out_stall,
    output t_dp_cmd o_cmd
);

    localparam logic StIdle = 1'b0;
    localparam logic StSend = 1'b1;

    logic       r_state, n_state;
    logic [4:0] r_pos, n_pos;
    logic       r_out_valid, n_out_valid;

    logic emit;
    logic last;
    logic accept;

    assign last   = (r_pos == PosLast);
    assign emit   = (r_state == StSend) && (!r_out_valid || !i_out_stall);
    // Take the next transaction in the cycle the final byte is built.
    assign o_in_stall = (r_state == StSend) && !(emit && last);
    assign accept = i_in_valid && !o_in_stall;

    always_comb begin
        n_state     = r_state;
        n_pos       = r_pos;
        n_out_valid = emit || (r_out_valid && i_out_stall);
        case (r_state)
            StIdle: begin
                if (accept) begin
                    n_state = StSend;
                    n_pos   = '0;
                end
            end
            StSend: begin
                if (emit) begin
                    if (last) begin
                        n_pos   = '0;
                        n_state = accept ? StSend : StIdle;
                    end else begin
                        n_pos = r_pos + 5'd1;
                    end
                end
            end
            default: begin
                n_state = StIdle;
                n_pos   = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= StIdle;
            r_pos       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pos       <= n_pos;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_cmd.load  = accept;
    assign o_cmd.emit  = emit;
    assign o_cmd.pos   = r_pos;

endmodule

[design/ascii_hex_sensor_frame_builder.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ascii_hex_sensor_frame_builder
// Turns one device id and one 16-bit reading into a 21-byte ASCII frame.
// ----------------------------------------------------------------------------
// Input channel: i_in_valid / i_in_data / o_in_stall, one transaction holds
// device_id and reading. Output channel: o_out_valid / o_out_data /
// i_out_stall, one frame character per transaction, frame_end set on LF.
// Frame: ':' id(2 hex) "03" reading(4 hex) x3 checksum(2 hex) CR LF, where
// the checksum is the 8-bit sum of the first 17 characters.
// The input transaction is registered with the sequencer state, and the
// first byte is then built into the output register. Throughput: one byte
// per cycle while the receiver never stalls; the position counter paces it.
// The next input transaction is taken in the cycle the LF byte is built,
// so frames follow each other without a gap.
// Reset (synchronous, active low) drops any frame in flight and clears
// the output valid. A stall on the output holds the current byte and
// freezes the sequencer; the input stays stalled until the frame is done.
// ----------------------------------------------------------------------------
module ascii_hex_sensor_frame_builder
    import ahsfb_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  t_in_item  i_in_data,
    output logic      o_in_stall,
    output logic      o_out_valid,
    output t_out_item o_out_data,
    input  logic      i_out_stall
);

    t_dp_cmd cmd;

    ahsfb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd)
    );

    ahsfb_dp u_dp (
        .i_clk      (i_clk),
        .i_cmd      (cmd),
        .i_in_data  (i_in_data),
        .o_out_data (o_out_data)
    );

endmodule

[design/ahsfb_chk.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ahsfb_chk
// Port-level checks for the frame builder, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ahsfb_chk
    import ahsfb_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input t_in_item  i_in_data,
    input logic      o_in_stall,
    input logic      o_out_valid,
    input t_out_item o_out_data,
    input logic      i_out_stall
);

    `ASSERT_CLK_ALL(a_rst_clears_out, i_clk, !i_rst_n |=> !o_out_valid, "out valid after reset")
    `ASSERT_CLK(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data), "stalled byte changed")
    `ASSERT_CLK(a_in_busy, i_clk, i_rst_n, i_in_valid && !o_in_stall |=> o_in_stall, "second input taken at once")
    `ASSERT_CLK(a_end_is_lf, i_clk, i_rst_n, o_out_valid && o_out_data.frame_end |-> o_out_data.out_byte == ChLf, "frame end not LF")

endmodule

bind ascii_hex_sensor_frame_builder ahsfb_chk u_ahsfb_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .i_in_data   (i_in_data),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .o_out_data  (o_out_data),
    .i_out_stall (i_out_stall)
);

[sim/ascii_hex_sensor_frame_builder_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ascii_hex_sensor_frame_builder_tb
// Feeds id/reading pairs into the frame builder and checks every frame byte.
// Each accepted input is expanded into its 21 expected characters (header,
// tripled reading, checksum, CR LF) and queued; each output transaction is
// compared against the oldest queued character. Both channels idle at
// random, with one stretch of no idling and one long receiver hold-off.
// ----------------------------------------------------------------------------
module ascii_hex_sensor_frame_builder_tb;
    import ahsfb_pkg::*;

    class frame_checker;
        t_out_item   pending_chars[$];
        int unsigned frames_noted;
        int unsigned chars_checked;
        int unsigned mismatches;

        function new();
            frames_noted  = 0;
            chars_checked = 0;
            mismatches    = 0;
        endfunction

        static function logic [7:0] nibble_ascii(input logic [3:0] nib);
            logic [7:0] ch;
            if (nib > 4'd9) begin
                ch = ChLetterA + {4'd0, nib} - 8'd10;
            end else begin
                ch = ChZero + {4'd0, nib};
            end
            return ch;
        endfunction

        function void add_char(input logic [7:0] ch, input logic last);
            t_out_item c;
            c.out_byte  = ch;
            c.frame_end = last;
            pending_chars.push_back(c);
        endfunction

        // Expand one accepted transaction into the characters of its frame.
        function void note_reading(input t_in_item it);
            logic [7:0] body [SumLen];
            logic [7:0] sum;
            int         p;
            body[0] = ChColon;
            body[1] = nibble_ascii(it.device_id[7:4]);
            body[2] = nibble_ascii(it.device_id[3:0]);
            body[3] = ChZero;
            body[4] = ChThree;
            for (p = 0; p < 3; p++) begin
                body[5 + 4 * p] = nibble_ascii(it.reading[15:12]);
                body[6 + 4 * p] = nibble_ascii(it.reading[11:8]);
                body[7 + 4 * p] = nibble_ascii(it.reading[7:4]);
                body[8 + 4 * p] = nibble_ascii(it.reading[3:0]);
            end
            sum = 8'd0;
            for (p = 0; p < SumLen; p++) begin
                sum = sum + body[p];
                add_char(body[p], 1'b0);
            end
            add_char(nibble_ascii(sum[7:4]), 1'b0);
            add_char(nibble_ascii(sum[3:0]), 1'b0);
            add_char(ChCr, 1'b0);
            add_char(ChLf, 1'b1);
            frames_noted++;
        endfunction

        function void check_char(input t_out_item got);
            t_out_item want;
            chars_checked++;
            if (pending_chars.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("mismatch at %0t: nothing expected, got byte %h end %b",
                             $time, got.out_byte, got.frame_end);
                end
                return;
            end
            want = pending_chars.pop_front();
            if (got.out_byte !== want.out_byte || got.frame_end !== want.frame_end) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("mismatch at %0t: expected byte %h end %b, got byte %h end %b",
                             $time, want.out_byte, want.frame_end,
                             got.out_byte, got.frame_end);
                end
            end
        endfunction
    endclass

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    t_in_item  i_in_data   = '0;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_item o_out_data;
    logic      i_out_stall = 1'b0;

    bit tx_idle_on   = 1'b1;
    bit rx_idle_on   = 1'b1;
    bit hold_off_req = 1'b0;
    int hold_left    = 0;

    frame_checker sb = new();

    ascii_hex_sensor_frame_builder dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Note every transaction on both channels at the rising edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                sb.note_reading(i_in_data);
            end
            if (o_out_valid && !i_out_stall) begin
                sb.check_char(o_out_data);
            end
        end
    end

    // Receiver: random stalls, plus one long hold-off on request.
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                hold_left    = 160;
            end
            if (hold_left != 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= rx_idle_on && ($urandom_range(99) < 37);
            end
        end
    end

    task automatic send_reading(input logic [7:0] id, input logic [15:0] rd);
        t_in_item it;
        it.device_id = id;
        it.reading   = rd;
        while (tx_idle_on && $urandom_range(99) < 37) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        // hold the payload until the block takes it
        do begin
            @(posedge i_clk);
        end while (o_in_stall);
    endtask

    initial begin
        int n;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // extremes, every hex letter and digit, digit/letter boundaries
        send_reading(8'h00, 16'h0000);
        send_reading(8'hFF, 16'hFFFF);
        send_reading(8'h09, 16'h0A9F);
        send_reading(8'hA0, 16'hF0A9);
        send_reading(8'h12, 16'h3456);
        send_reading(8'hAB, 16'hCDEF);
        send_reading(8'h78, 16'h9ABC);
        send_reading(8'h5A, 16'hA5A5);
        send_reading(8'h80, 16'h8000);
        send_reading(8'h01, 16'h0001);
        send_reading(8'h7F, 16'h7FFF);
        send_reading(8'hFE, 16'hFEDC);
        send_reading(8'hC3, 16'h3C3C);

        // long receiver hold-off while the sender keeps offering
        hold_off_req = 1'b1;
        for (n = 0; n < 248; n++) begin
            if (n == 70) begin
                tx_idle_on = 1'b0;
                rx_idle_on = 1'b0;
            end else if (n == 150) begin
                tx_idle_on = 1'b1;
                rx_idle_on = 1'b1;
            end
            send_reading(8'($urandom_range(255)), 16'($urandom_range(65535)));
        end
        @(negedge i_clk);
        i_in_valid <= 1'b0;

        while (sb.pending_chars.size() != 0) begin
            @(posedge i_clk);
        end
        // catch stray characters after the last frame
        repeat (30) @(posedge i_clk);

        $display("covered %0d frames (directed extremes and random), %0d characters checked",
                 sb.frames_noted, sb.chars_checked);
        $display("mismatches: %0d, characters still expected: %0d",
                 sb.mismatches, sb.pending_chars.size());
        if (sb.mismatches == 0 && sb.pending_chars.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        #400000;
        $display("status: fail");
        $finish;
    end

endmodule
